/* rtl/assert_macros.svh */
// assertion macros used by the checker file ils_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ILS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define ILS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/ils_pkg.sv */
// shared types and constants of the indexed list store
// used by the controller, datapath, top level and checker
package ils_pkg;

  localparam int ILS_DEPTH       = 16;
  localparam int ILS_VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    ACT_INSERT       = 3'd0,
    ACT_REMOVE_AT    = 3'd1,
    ACT_POP          = 3'd2,
    ACT_REMOVE_VALUE = 3'd3,
    ACT_CLEAR        = 3'd4,
    ACT_FIND         = 3'd5,
    ACT_GET          = 3'd6,
    ACT_SET          = 3'd7
  } ils_action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTFOUND = 3'd5
  } ils_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SU_MOVE,
    S_INS_WRITE,
    S_SD_MOVE,
    S_SD_DONE,
    S_SCAN,
    S_GET,
    S_FINISH
  } ils_state_t;

  typedef enum logic [4:0] {
    C_NONE,
    C_LOAD,
    C_FAIL,
    C_SU_INIT,
    C_SU_MOVE,
    C_INS_WRITE,
    C_SD_INIT,
    C_SD_MOVE,
    C_SD_DONE,
    C_POP,
    C_CLEAR,
    C_SET,
    C_SCAN_INIT,
    C_SCAN,
    C_GET_ISSUE,
    C_GET,
    C_FINISH
  } ils_cmd_t;

  typedef struct packed {
    ils_code_t   check_err;
    ils_action_t act;
    logic        at_count;
    logic        rm_last;
    logic        su_last;
    logic        sd_last;
    logic        sd_move_last;
    logic        match;
    logic        out_free;
  } ils_flags_t;

endpackage

/* rtl/ils_req_if.sv */
// request channel of the indexed list store: valid/ready plus operation fields
// no dependencies
interface ils_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [4:0]  position;
  logic [31:0] value;

  modport source(output valid, action, position, value, input ready);
  modport sink(input valid, action, position, value, output ready);
endinterface

/* rtl/ils_rsp_if.sv */
// result channel of the indexed list store: valid/ready plus result fields
// no dependencies
interface ils_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  status;
  logic [3:0]  found_position;
  logic [31:0] read_value;
  logic [4:0]  entry_count;

  modport source(output valid, ok, status, found_position, read_value, entry_count,
                 input ready);
  modport sink(input valid, ok, status, found_position, read_value, entry_count,
               output ready);
endinterface

/* rtl/ils_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ils_ctrl.sv */
// sequencing state machine of the indexed list store
// depends on ils_pkg; drives datapath commands from its flags
module ils_ctrl import ils_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  ils_flags_t flags,
  output logic       in_ready,
  output ils_cmd_t   cmd
);

  ils_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (flags.check_err != ST_OK) begin
          state_next = S_FINISH;
        end else begin
          unique case (flags.act)
            ACT_INSERT:       state_next = flags.at_count ? S_FINISH : S_SU_MOVE;
            ACT_REMOVE_AT:    state_next = flags.rm_last ? S_FINISH : S_SD_MOVE;
            ACT_REMOVE_VALUE,
            ACT_FIND:         state_next = S_SCAN;
            ACT_GET:          state_next = S_GET;
            ACT_POP,
            ACT_CLEAR,
            ACT_SET:          state_next = S_FINISH;
          endcase
        end
      end
      S_SU_MOVE: begin
        if (flags.su_last) state_next = S_INS_WRITE;
      end
      S_INS_WRITE: state_next = S_FINISH;
      S_SD_MOVE: begin
        if (flags.sd_move_last) state_next = S_SD_DONE;
      end
      S_SD_DONE: state_next = S_FINISH;
      S_SCAN: begin
        if (flags.match) begin
          if (flags.act == ACT_FIND) begin
            state_next = S_FINISH;
          end else begin
            state_next = flags.sd_last ? S_SD_DONE : S_SD_MOVE;
          end
        end else if (flags.sd_last) begin
          state_next = S_FINISH;
        end
      end
      S_GET: state_next = S_FINISH;
      S_FINISH: begin
        if (flags.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd      = C_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) cmd = C_LOAD;
      end
      S_CHECK: begin
        if (flags.check_err != ST_OK) begin
          cmd = C_FAIL;
        end else begin
          unique case (flags.act)
            ACT_INSERT:       cmd = flags.at_count ? C_INS_WRITE : C_SU_INIT;
            ACT_REMOVE_AT:    cmd = flags.rm_last ? C_SD_DONE : C_SD_INIT;
            ACT_POP:          cmd = C_POP;
            ACT_CLEAR:        cmd = C_CLEAR;
            ACT_REMOVE_VALUE,
            ACT_FIND:         cmd = C_SCAN_INIT;
            ACT_GET:          cmd = C_GET_ISSUE;
            ACT_SET:          cmd = C_SET;
          endcase
        end
      end
      S_SU_MOVE:   cmd = C_SU_MOVE;
      S_INS_WRITE: cmd = C_INS_WRITE;
      S_SD_MOVE:   cmd = C_SD_MOVE;
      S_SD_DONE:   cmd = C_SD_DONE;
      S_SCAN:      cmd = C_SCAN;
      S_GET:       cmd = C_GET;
      S_FINISH: begin
        if (flags.out_free) cmd = C_FINISH;
      end
      default: cmd = C_NONE;
    endcase
  end

endmodule

/* rtl/ils_dpath.sv */
// datapath of the indexed list store: entry RAM, count, walk index, result register
// depends on ils_pkg and ils_ram; executes commands from ils_ctrl
module ils_dpath import ils_pkg::*; #(
  parameter int DEPTH       = ILS_DEPTH,
  parameter int VALUE_WIDTH = ILS_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  ils_cmd_t    cmd,
  input  logic [2:0]  action,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  input  logic        out_ready,
  output ils_flags_t  flags,
  output logic        out_valid,
  output logic        ok,
  output logic [2:0]  status,
  output logic [3:0]  found_position,
  output logic [31:0] read_value,
  output logic [4:0]  entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 5) ? CW : 5) + 1;

  ils_action_t            act;
  logic [4:0]             pos;
  logic [VALUE_WIDTH-1:0] word;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  ils_code_t              res_status;
  logic [3:0]             res_found;
  logic [31:0]            res_read;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          cnt_x;
  logic [XW-1:0]          idx_x;
  logic                   is_null;
  logic                   is_empty;
  ils_code_t              chk;

  ils_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign pos_x    = XW'(pos);
  assign cnt_x    = XW'(count);
  assign idx_x    = XW'(idx);
  assign is_null  = (word == '0);
  assign is_empty = (count == '0);

  // checks in priority order per operation
  always_comb begin
    chk = ST_OK;
    unique case (act)
      ACT_INSERT: begin
        if (is_null) chk = ST_NULL;
        else if (pos_x > cnt_x) chk = ST_BADPOS;
        else if (cnt_x >= XW'(DEPTH)) chk = ST_FULL;
      end
      ACT_REMOVE_AT: begin
        if (is_empty) chk = ST_EMPTY;
        else if (pos_x >= cnt_x) chk = ST_BADPOS;
      end
      ACT_POP, ACT_CLEAR: begin
        if (is_empty) chk = ST_EMPTY;
      end
      ACT_REMOVE_VALUE: begin
        if (is_null) chk = ST_NULL;
        else if (is_empty) chk = ST_EMPTY;
      end
      ACT_FIND: begin
        if (is_null) chk = ST_NULL;
        else if (is_empty) chk = ST_NOTFOUND;
      end
      ACT_GET: begin
        if (pos_x >= cnt_x) chk = ST_BADPOS;
      end
      ACT_SET: begin
        if (is_null) chk = ST_NULL;
        else if (pos_x >= cnt_x) chk = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    flags.check_err    = chk;
    flags.act          = act;
    flags.at_count     = (pos_x == cnt_x);
    flags.rm_last      = (pos_x + XW'(1) >= cnt_x);
    flags.su_last      = (idx_x == pos_x);
    flags.sd_last      = (idx_x + XW'(1) >= cnt_x);
    flags.sd_move_last = (idx_x + XW'(2) >= cnt_x);
    flags.match        = (rdata == word);
    flags.out_free     = !out_valid || out_ready;
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = AW'(idx);
    wdata = rdata;
    raddr = AW'(idx);
    unique case (cmd)
      C_SU_INIT:   raddr = AW'(count - CW'(1));
      C_SU_MOVE: begin
        raddr = AW'(idx - CW'(1));
        we    = 1'b1;
        waddr = AW'(idx_x + XW'(1));
      end
      C_INS_WRITE, C_SET: begin
        we    = 1'b1;
        waddr = AW'(pos);
        wdata = word;
      end
      C_SD_INIT:   raddr = AW'(pos_x + XW'(1));
      C_SD_MOVE: begin
        raddr = AW'(idx_x + XW'(2));
        we    = 1'b1;
      end
      C_SCAN_INIT: raddr = '0;
      C_SCAN:      raddr = AW'(idx_x + XW'(1));
      C_GET_ISSUE: raddr = AW'(pos);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd)
        C_INS_WRITE:       count <= count + CW'(1);
        C_POP, C_SD_DONE:  count <= count - CW'(1);
        C_CLEAR:           count <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      C_LOAD: begin
        act        <= ils_action_t'(action);
        pos        <= position;
        word       <= VALUE_WIDTH'(value);
        res_status <= ST_OK;
        res_found  <= '0;
        res_read   <= '0;
      end
      C_FAIL:      res_status <= chk;
      C_SU_INIT:   idx <= count - CW'(1);
      C_SU_MOVE:   idx <= idx - CW'(1);
      C_SD_INIT:   idx <= CW'(pos);
      C_SD_MOVE:   idx <= idx + CW'(1);
      C_SCAN_INIT: idx <= '0;
      C_SCAN: begin
        if (flags.match) begin
          if (act == ACT_FIND) res_found <= 4'(idx);
        end else if (flags.sd_last) begin
          res_status <= ST_NOTFOUND;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      C_GET:       res_read <= 32'(rdata);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == C_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == C_FINISH) begin
      ok             <= (res_status == ST_OK);
      status         <= res_status;
      found_position <= res_found;
      read_value     <= res_read;
      entry_count    <= 5'(count);
    end
  end

endmodule

/* rtl/indexed_list_store.sv */
// insert, remove_at, find and remove_value walk the entry RAM one entry per cycle;
//   pop, clear, set, get, append and failed checks finish without a walk
// throughput: one item at a time; the next item is taken once the result is registered
// reset clears the entry count and the handshake state; entry storage is not cleared
// top level: joins controller, datapath and the request/result channels; depends on ils_pkg
module indexed_list_store import ils_pkg::*; #(
  parameter int DEPTH       = ILS_DEPTH,
  parameter int VALUE_WIDTH = ILS_VALUE_WIDTH
) (
  input logic        clk,
  input logic        rst,
  ils_req_if.sink    request,
  ils_rsp_if.source  result
);

  ils_cmd_t   cmd;
  ils_flags_t flags;
  logic       in_ready;

  assign request.ready = in_ready;

  ils_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(request.valid),
    .flags   (flags),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  ils_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (request.action),
    .position      (request.position),
    .value         (request.value),
    .out_ready     (result.ready),
    .flags         (flags),
    .out_valid     (result.valid),
    .ok            (result.ok),
    .status        (result.status),
    .found_position(result.found_position),
    .read_value    (result.read_value),
    .entry_count   (result.entry_count)
  );

endmodule

/* rtl/ils_checker.sv */
// port-level assertions for the indexed list store, bound to the top level
// depends on ils_pkg and assert_macros.svh
`include "assert_macros.svh"

module ils_checker import ils_pkg::*; #(
  parameter int DEPTH = ILS_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_ok,
  input logic [2:0]  rsp_status,
  input logic [3:0]  rsp_found,
  input logic [31:0] rsp_read,
  input logic [4:0]  rsp_count
);

  `ILS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_read))
  `ILS_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `ILS_ASSERT_NOW(a_fail_clean, clk, rst, rsp_valid && (rsp_status != ST_OK), !rsp_ok && (rsp_read == 32'd0) && (rsp_found == 4'd0))
  `ILS_ASSERT_NOW(a_full_count, clk, rst, rsp_valid && (rsp_status == ST_FULL), rsp_count == 5'(DEPTH))
  `ILS_ASSERT_NOW(a_empty_count, clk, rst, rsp_valid && (rsp_status == ST_EMPTY), rsp_count == 5'd0)

endmodule

bind indexed_list_store ils_checker #(.DEPTH(DEPTH)) u_ils_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(request.valid),
  .req_ready(request.ready),
  .rsp_valid(result.valid),
  .rsp_ready(result.ready),
  .rsp_ok   (result.ok),
  .rsp_status(result.status),
  .rsp_found(result.found_position),
  .rsp_read (result.read_value),
  .rsp_count(result.entry_count)
);
